>>> rtl/core/ahi_pkg.sv
// ahi_pkg: shared types and constants for the attitude history interpolator
// no dependencies
package ahi_pkg;

  localparam int unsigned HistDepthDefault = 128;
  localparam logic signed [17:0] PiQ12 = 18'sd12868;
  localparam logic signed [17:0] TwoPiQ12 = 18'sd25736;

  typedef enum logic [1:0] {
    StatEmpty  = 2'd0,
    StatSample = 2'd1,
    StatInterp = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    StIdle,
    StScanRd,
    StScanCmp,
    StRdB,
    StRdA,
    StLatA,
    StDiv,
    StMul,
    StEmit,
    StOut
  } state_e;

  // divider control between sequencer and divider
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

endpackage

>>> rtl/core/ahi_div.sv
// ahi_div: restoring serial divider, one quotient bit per cycle
// no dependencies
module ahi_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        busy_o,
  output logic [15:0] quot_o
);
  // computes min(floor(num*65536/den), 65535), num < den assumed ok too
  logic [32:0] rem_q, rem_d;
  logic [47:0] dvd_q, dvd_d;
  logic [31:0] den_q, den_d;
  logic [47:0] quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [33:0] trial;
  logic [32:0] shifted;

  always_comb begin
    rem_d = rem_q; dvd_d = dvd_q; den_d = den_q; quo_d = quo_q;
    cnt_d = cnt_q; busy_d = busy_q;
    shifted = {rem_q[31:0], dvd_q[47]};
    trial = {1'b0, shifted} - {2'b00, den_q};
    if (start_i) begin
      rem_d = '0; dvd_d = {num_i, 16'h0}; den_d = den_i; quo_d = '0;
      cnt_d = 6'd48; busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[46:0], 1'b0};
      if (!trial[33]) begin
        rem_d = trial[32:0]; quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = shifted; quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; dvd_q <= dvd_d; den_q <= den_d; quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  // zero divisor gives zero, overflow clamps
  assign quot_o = (den_q == 32'h0) ? 16'h0 :
                  (quo_q[47:16] != 32'h0) ? 16'hFFFF : quo_q[15:0];
endmodule

>>> rtl/core/attitude_history_interpolator.sv
// attitude_history_interpolator: timestamped attitude history with interpolation
// a store is written on accept and the next transaction can follow right after it
// a query scans the history oldest first, one read and compare per entry, up to the
// first newer entry, then reads the two neighbours; one side only or one entry
// gives a held sample, else the serial divider interpolates; empty status if empty
// reset clears fill count, oldest slot, state, output valid and yaw_clockwise (to 1)
module attitude_history_interpolator #(
  parameter int unsigned HistoryDepth = ahi_pkg::HistDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [31:0] stamp_i,
  input  logic signed [15:0] roll_in_i,
  input  logic signed [15:0] pitch_in_i,
  input  logic signed [15:0] yaw_in_i,
  input  logic [7:0]  quality_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] stamp_out_o,
  output logic signed [15:0] roll_out_o,
  output logic signed [15:0] pitch_out_o,
  output logic signed [15:0] yaw_out_o,
  output logic [7:0]  quality_out_o
);
  localparam int unsigned AW = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1;
  localparam int unsigned CW = $clog2(HistoryDepth + 1);
  localparam logic [CW-1:0] DepthC = CW'(HistoryDepth);
  localparam logic [AW-1:0] LastC = AW'(HistoryDepth - 1);

  // history memory, one packed word per entry
  logic [87:0] mem [HistoryDepth];
  logic [87:0] rd_q;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [87:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  ahi_pkg::state_e st_q, st_d;
  logic [AW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] fill_q, fill_d, pos_q, pos_d;
  logic          ycw_q;
  logic [31:0]   t_q, t_d;
  logic [AW-1:0] bidx_q, bidx_d, aidx_q, aidx_d;
  logic          hb_q, hb_d, ha_q, ha_d;
  logic [87:0]   b_q, b_d, a_q, a_d;
  logic [1:0]    ang_q, ang_d;
  logic signed [15:0] r_q [3];
  logic signed [15:0] r_d [3];
  logic [1:0]    ostat_q, ostat_d;
  logic [31:0]   ostamp_q, ostamp_d;
  logic [7:0]    oqual_q, oqual_d;
  logic          ovld_q, ovld_d;
  logic signed [33:0] prod_q, prod_d;
  ahi_pkg::div_ctl_t dctl;
  logic [15:0]   alpha;

  ahi_div u_div (
    .clk_i, .rst_ni, .start_i(dctl.start),
    .num_i(t_q - b_q[87:56]), .den_i(a_q[87:56] - b_q[87:56]),
    .busy_o(dctl.busy), .quot_o(alpha)
  );

  // slot of a position relative to the oldest entry
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] o, input logic [CW-1:0] p);
    logic [CW:0] s;
    begin
      s = {1'b0, p} + (CW+1)'(o);
      if (s >= (CW+1)'(HistoryDepth)) s = s - (CW+1)'(HistoryDepth);
      slot = s[AW-1:0];
    end
  endfunction

  logic signed [16:0] yneg;
  logic signed [15:0] ysto;
  logic signed [17:0] dif, bsel;
  logic signed [33:0] addq;
  logic signed [18:0] sum;
  logic signed [15:0] sat;

  always_comb begin
    st_d = st_q; oldest_d = oldest_q; fill_d = fill_q; pos_d = pos_q; t_d = t_q;
    bidx_d = bidx_q; aidx_d = aidx_q; hb_d = hb_q; ha_d = ha_q; b_d = b_q; a_d = a_q;
    ang_d = ang_q; r_d = r_q; ostat_d = ostat_q; ostamp_d = ostamp_q;
    oqual_d = oqual_q; ovld_d = ovld_q; prod_d = prod_q;
    we = 1'b0; waddr = slot(oldest_q, fill_q); raddr = slot(oldest_q, pos_q);
    dctl.start = 1'b0;
    yneg = -{yaw_in_i[15], yaw_in_i};
    ysto = !ycw_q ? yaw_in_i : (yaw_in_i == 16'sh8000) ? 16'sh7FFF : yneg[15:0];
    wdata = {stamp_i, roll_in_i, pitch_in_i, ysto, quality_in_i};
    in_ready_o = (st_q == ahi_pkg::StIdle) && !ovld_q;
    // per-angle difference, yaw wrapped once
    case (ang_q)
      2'd0: bsel = 18'($signed(b_q[55:40]));
      2'd1: bsel = 18'($signed(b_q[39:24]));
      default: bsel = 18'($signed(b_q[23:8]));
    endcase
    case (ang_q)
      2'd0: dif = 18'($signed(a_q[55:40])) - 18'($signed(b_q[55:40]));
      2'd1: dif = 18'($signed(a_q[39:24])) - 18'($signed(b_q[39:24]));
      default: begin
        dif = 18'($signed(a_q[23:8])) - 18'($signed(b_q[23:8]));
        if (dif > ahi_pkg::PiQ12) dif = dif - ahi_pkg::TwoPiQ12;
        else if (dif < -ahi_pkg::PiQ12) dif = dif + ahi_pkg::TwoPiQ12;
      end
    endcase
    addq = prod_q + 34'sd32768;
    sum = 19'(bsel) + 19'(addq >>> 16);
    sat = (sum > 19'sd32767) ? 16'sh7FFF : (sum < -19'sd32768) ? 16'sh8000 : sum[15:0];
    if (ovld_q && out_ready_i) ovld_d = 1'b0;
    case (st_q)
      ahi_pkg::StIdle: begin
        if (in_valid_i && in_ready_o) begin
          t_d = stamp_i;
          if (!mode_i) begin
            we = 1'b1;
            if (fill_q < DepthC) begin
              fill_d = fill_q + 1'b1;
            end else begin
              waddr = oldest_q;
              oldest_d = (oldest_q == LastC) ? '0 : oldest_q + 1'b1;
            end
          end else if (fill_q == '0) begin
            ostat_d = ahi_pkg::StatEmpty; ostamp_d = '0; oqual_d = '0;
            r_d[0] = '0; r_d[1] = '0; r_d[2] = '0; ovld_d = 1'b1;
          end else begin
            pos_d = '0; hb_d = 1'b0; ha_d = 1'b0; bidx_d = oldest_q;
            st_d = ahi_pkg::StScanRd;
          end
        end
      end
      ahi_pkg::StScanRd: st_d = ahi_pkg::StScanCmp;
      ahi_pkg::StScanCmp: begin
        if (rd_q[87:56] <= t_q) begin
          bidx_d = slot(oldest_q, pos_q); hb_d = 1'b1;
          if (pos_q + 1'b1 == fill_q) st_d = ahi_pkg::StRdB;
          else begin pos_d = pos_q + 1'b1; st_d = ahi_pkg::StScanRd; end
        end else begin
          aidx_d = slot(oldest_q, pos_q); ha_d = 1'b1; st_d = ahi_pkg::StRdB;
        end
      end
      ahi_pkg::StRdB: begin
        raddr = bidx_q; st_d = ahi_pkg::StRdA;
      end
      ahi_pkg::StRdA: begin
        raddr = aidx_q; b_d = rd_q; st_d = ahi_pkg::StLatA;
      end
      ahi_pkg::StLatA: begin
        a_d = rd_q;
        if (!hb_q || !ha_q || fill_q == CW'(1)) begin
          ostat_d = ahi_pkg::StatSample; ostamp_d = b_q[87:56];
          r_d[0] = b_q[55:40]; r_d[1] = b_q[39:24]; r_d[2] = b_q[23:8];
          oqual_d = b_q[7:0]; ovld_d = 1'b1; st_d = ahi_pkg::StIdle;
        end else begin
          st_d = ahi_pkg::StDiv;
        end
      end
      ahi_pkg::StDiv: begin
        dctl.start = 1'b1; ang_d = 2'd0; st_d = ahi_pkg::StMul;
      end
      ahi_pkg::StMul: begin
        if (!dctl.busy) begin
          prod_d = $signed({1'b0, alpha}) * dif; st_d = ahi_pkg::StEmit;
        end
      end
      ahi_pkg::StEmit: begin
        r_d[ang_q] = sat;
        if (ang_q == 2'd2) st_d = ahi_pkg::StOut;
        else begin ang_d = ang_q + 2'd1; st_d = ahi_pkg::StMul; end
      end
      ahi_pkg::StOut: begin
        ostat_d = ahi_pkg::StatInterp; ostamp_d = t_q;
        oqual_d = (b_q[7:0] < a_q[7:0]) ? b_q[7:0] : a_q[7:0];
        ovld_d = 1'b1; st_d = ahi_pkg::StIdle;
      end
      default: st_d = ahi_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ahi_pkg::StIdle; oldest_q <= '0; fill_q <= '0; ovld_q <= 1'b0;
      ycw_q <= 1'b1;
    end else begin
      st_q <= st_d; oldest_q <= oldest_d; fill_q <= fill_d; ovld_q <= ovld_d;
      if (cfg_valid_i) ycw_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; t_q <= t_d; bidx_q <= bidx_d; aidx_q <= aidx_d;
    hb_q <= hb_d; ha_q <= ha_d; b_q <= b_d; a_q <= a_d; ang_q <= ang_d;
    r_q <= r_d; ostat_q <= ostat_d; ostamp_q <= ostamp_d; oqual_q <= oqual_d;
    prod_q <= prod_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = ovld_q;
  assign status_o      = ostat_q;
  assign stamp_out_o   = ostamp_q;
  assign roll_out_o    = r_q[0];
  assign pitch_out_o   = r_q[1];
  assign yaw_out_o     = r_q[2];
  assign quality_out_o = oqual_q;

  // fill count never exceeds depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= DepthC)
    else $error("fill count overflow");
  // oldest slot moves only when history is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oldest_q != $past(oldest_q)) |-> (fill_q == DepthC))
    else $error("oldest moved before full");
  // no input taken while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> !in_ready_o)
    else $error("input accepted with pending result");
endmodule
